>>> src/fixed_block_pool_allocator_core_defines.svh
// Assertion macros shared by the allocator checker.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_DEFINES_SVH

// Clocked check, idle while reset is asserted.
`define FBPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fbpa: port check failed");

// Clocked check that is also evaluated during reset.
`define FBPA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("fbpa: reset check failed");

`endif

>>> src/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
`timescale 1ns / 1ps
`default_nettype none
package fbpa_pkg;

  localparam int unsigned BLOCKS  = 256;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned IDX_W   = $clog2(BLOCKS);
  localparam int unsigned LINK_W  = IDX_W + 1;          // {last, next index}
  localparam int unsigned OFF_W   = SIZE_W + IDX_W;     // offset inside the pool
  localparam int unsigned STEP_W  = $clog2(IDX_W);
  localparam int unsigned RES_W   = ADDR_W + 2;
  localparam int unsigned MIN_BLOCK_BYTES = 4;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_POOL_BASE   = 2'd0,
    REG_BLOCK_SIZE  = 2'd1,
    REG_BLOCK_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ALU_MAC = 1'b0,   // a + b[SIZE_W-1:0] * c
    ALU_SUB = 1'b1    // a - b, top bit is the borrow
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [ADDR_W:0]   a;
    logic [ADDR_W:0]   b;
    logic [CNT_W-1:0]  c;
  } alu_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_CHK,
    S_INIT_LINK,
    S_ALLOC_RD,
    S_ALLOC_UPD,
    S_FREE_LO,
    S_FREE_HI,
    S_FREE_DIV,
    S_FREE_PUSH,
    S_OUT
  } state_e;

endpackage
`default_nettype wire

>>> src/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> src/fbpa_alu.sv
// Shared multiply-add / subtract unit of the allocator sequencer.
`timescale 1ns / 1ps
`default_nettype none
module fbpa_alu (
  input  wire fbpa_pkg::alu_req_t          req_i,
  output logic [fbpa_pkg::RES_W-1:0]       res_o
);
  import fbpa_pkg::*;

  logic [SIZE_W+CNT_W-1:0] prod;

  assign prod = req_i.b[SIZE_W-1:0] * req_i.c;

  always_comb begin
    unique case (req_i.op)
      ALU_MAC: res_o = {1'b0, req_i.a} + RES_W'(prod);
      ALU_SUB: res_o = {1'b0, req_i.a} - {1'b0, req_i.b};
      default: res_o = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> src/fixed_block_pool_allocator_core.sv
// Top level of the fixed block pool allocator: sequencer, state and result register.
// A pool of number_of_blocks equal blocks starting at pool_base, kept as a LIFO
// free list of block indices in a 256 x 9 link RAM ({last flag, next index}).
// Each input item carries an opcode in s_axis_tuser (init, alloc, free) and, for
// free, a byte address in s_axis_tdata; each item gives exactly one result item.
// Items are handled one at a time; s_axis_tready is high only while the
// sequencer is idle, and a finished result waits in the output register so the
// next item can be taken meanwhile. Steps from accept to result valid:
//   init  : a check, then one link RAM write per block
//   alloc : RAM read of the head link, then its registered read data
//   free  : two range compares, one quotient bit per cycle, then the push
//   other : straight to the result
// The steps are set by the single shared subtract/multiply-add unit, which
// produces one quotient bit per cycle for the block index of a free, and by the
// one RAM write port that the init link sweep uses. The link RAM needs no
// clearing pass: only entries written by init are ever linked.
// Configuration writes (pool_base, size_of_block, number_of_blocks) take effect
// on the next init and must be made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module fixed_block_pool_allocator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] block_address
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [31:0] granted_address, [40:32] blocks_free
  output logic [0:0]       m_axis_tuser    // [0] success
);
  import fbpa_pkg::*;

  // configuration registers
  logic [ADDR_W-1:0] cfg_base_q, cfg_base_d;
  logic [SIZE_W-1:0] cfg_size_q, cfg_size_d;
  logic [CNT_W-1:0]  cfg_count_q, cfg_count_d;

  // pool state
  logic [ADDR_W-1:0] act_base_q, act_base_d;
  logic [SIZE_W-1:0] act_size_q, act_size_d;
  logic [CNT_W-1:0]  act_count_q, act_count_d;
  logic [ADDR_W:0]   act_end_q, act_end_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic              empty_q, empty_d;
  logic [CNT_W-1:0]  tally_q, tally_d;

  // per-item working registers
  state_e            state_q, state_d;
  logic [ADDR_W-1:0] op_addr_q, op_addr_d;
  logic [OFF_W-1:0]  rem_q, rem_d;
  logic [IDX_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [IDX_W-1:0]  link_idx_q, link_idx_d;
  logic              res_ok_q, res_ok_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;

  // output register
  logic              m_valid_q, m_valid_d;
  logic [47:0]       m_data_q, m_data_d;
  logic              m_ok_q, m_ok_d;

  // shared unit and link RAM
  alu_req_t          alu_req;
  logic [RES_W-1:0]  alu_res;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [LINK_W-1:0] ram_wdata, ram_rdata;

  logic              in_acc, out_free;
  logic [SIZE_W-1:0] size_eff;
  logic              init_fail, lo_fail, hi_fail, link_last;
  logic [IDX_W-1:0]  link_nxt;

  fbpa_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_ok_q;

  // block size is raised to the minimum at init
  assign size_eff = (cfg_size_q < SIZE_W'(MIN_BLOCK_BYTES)) ? SIZE_W'(MIN_BLOCK_BYTES)
                                                            : cfg_size_q;

  // alu holds base + size * count in the init check; region may end at 2^32 exactly
  assign init_fail = (cfg_count_q == '0) || (cfg_count_q > CNT_W'(BLOCKS)) ||
                     (cfg_base_q == '0) || alu_res[RES_W-1] ||
                     (alu_res[ADDR_W] && (alu_res[ADDR_W-1:0] != '0));

  // free: zero address, no pool yet, or below base (borrow)
  assign lo_fail = (op_addr_q == '0) || (act_count_q == '0) || alu_res[RES_W-1];
  // free: at or past the end of the region (no borrow)
  assign hi_fail = !alu_res[RES_W-1];

  assign link_last = ((CNT_W'(link_idx_q) + CNT_W'(1)) == act_count_q);
  assign link_nxt  = link_last ? '0 : link_idx_q + IDX_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (s_axis_tuser)
            OP_INIT:  state_d = S_INIT_CHK;
            OP_ALLOC: state_d = S_ALLOC_RD;
            OP_FREE:  state_d = S_FREE_LO;
            default:  state_d = S_OUT;
          endcase
        end
      end
      S_INIT_CHK:  state_d = init_fail ? S_OUT : S_INIT_LINK;
      S_INIT_LINK: state_d = link_last ? S_OUT : S_INIT_LINK;
      S_ALLOC_RD:  state_d = empty_q ? S_OUT : S_ALLOC_UPD;
      S_ALLOC_UPD: state_d = S_OUT;
      S_FREE_LO:   state_d = lo_fail ? S_OUT : S_FREE_HI;
      S_FREE_HI:   state_d = hi_fail ? S_OUT : S_FREE_DIV;
      S_FREE_DIV:  state_d = (step_q == '0) ? S_FREE_PUSH : S_FREE_DIV;
      S_FREE_PUSH: state_d = S_OUT;
      S_OUT:       state_d = out_free ? S_IDLE : S_OUT;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cfg_base_d  = cfg_base_q;
    cfg_size_d  = cfg_size_q;
    cfg_count_d = cfg_count_q;
    act_base_d  = act_base_q;
    act_size_d  = act_size_q;
    act_count_d = act_count_q;
    act_end_d   = act_end_q;
    head_d      = head_q;
    empty_d     = empty_q;
    tally_d     = tally_q;
    op_addr_d   = op_addr_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    link_idx_d  = link_idx_q;
    res_ok_d    = res_ok_q;
    res_addr_d  = res_addr_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    m_ok_d      = m_ok_q;

    alu_req.op  = ALU_SUB;
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.c   = '0;

    ram_we      = 1'b0;
    ram_waddr   = link_idx_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = head_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POOL_BASE:   cfg_base_d  = cfg_wdata_i;
        REG_BLOCK_SIZE:  cfg_size_d  = cfg_wdata_i[SIZE_W-1:0];
        REG_BLOCK_COUNT: cfg_count_d = cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_addr_d  = s_axis_tdata;
          res_ok_d   = 1'b0;
          res_addr_d = '0;
        end
      end
      S_INIT_CHK: begin
        alu_req.op = ALU_MAC;
        alu_req.a  = {1'b0, cfg_base_q};
        alu_req.b  = (ADDR_W+1)'(size_eff);
        alu_req.c  = cfg_count_q;
        if (!init_fail) begin
          act_base_d  = cfg_base_q;
          act_size_d  = size_eff;
          act_count_d = cfg_count_q;
          act_end_d   = alu_res[ADDR_W:0];
          tally_d     = cfg_count_q;
          head_d      = '0;
          empty_d     = 1'b0;
          link_idx_d  = '0;
        end
      end
      S_INIT_LINK: begin
        ram_we     = 1'b1;
        ram_waddr  = link_idx_q;
        ram_wdata  = {link_last, link_nxt};
        link_idx_d = link_idx_q + IDX_W'(1);
        if (link_last) begin
          res_ok_d = 1'b1;
        end
      end
      S_ALLOC_RD: begin
        alu_req.op = ALU_MAC;
        alu_req.a  = {1'b0, act_base_q};
        alu_req.b  = (ADDR_W+1)'(act_size_q);
        alu_req.c  = CNT_W'(head_q);
        if (!empty_q) begin
          ram_re     = 1'b1;
          ram_raddr  = head_q;
          res_addr_d = alu_res[ADDR_W-1:0];
        end
      end
      S_ALLOC_UPD: begin
        if (ram_rdata[LINK_W-1]) begin
          empty_d = 1'b1;
        end else begin
          head_d = ram_rdata[IDX_W-1:0];
        end
        if (tally_q != '0) begin
          tally_d = tally_q - CNT_W'(1);
        end
        res_ok_d = 1'b1;
      end
      S_FREE_LO: begin
        alu_req.a = {1'b0, op_addr_q};
        alu_req.b = {1'b0, act_base_q};
        rem_d     = alu_res[OFF_W-1:0];
      end
      S_FREE_HI: begin
        alu_req.a = {1'b0, op_addr_q};
        alu_req.b = act_end_q;
        quo_d     = '0;
        step_d    = STEP_W'(IDX_W - 1);
      end
      S_FREE_DIV: begin
        // restoring division, one quotient bit per cycle
        alu_req.a = (ADDR_W+1)'(rem_q);
        alu_req.b = (ADDR_W+1)'(act_size_q) << step_q;
        if (!alu_res[RES_W-1]) begin
          rem_d         = alu_res[OFF_W-1:0];
          quo_d[step_q] = 1'b1;
        end
        step_d = step_q - STEP_W'(1);
      end
      S_FREE_PUSH: begin
        // off a block boundary: remainder left
        if (rem_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = quo_q;
          ram_wdata = {empty_q, head_q};
          head_d    = quo_q;
          empty_d   = 1'b0;
          if (tally_q < CNT_W'(BLOCKS)) begin
            tally_d = tally_q + CNT_W'(1);
          end
          res_ok_d  = 1'b1;
        end
      end
      S_OUT: ;
      default: ;
    endcase

    // result register: load when the slot is free, else drain on ready
    if ((state_q == S_OUT) && out_free) begin
      m_valid_d = 1'b1;
      m_data_d  = {7'b0, tally_q, res_addr_q};
      m_ok_d    = res_ok_q;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_base_q  <= '0;
      cfg_size_q  <= SIZE_W'(MIN_BLOCK_BYTES);
      cfg_count_q <= CNT_W'(1);
      act_base_q  <= '0;
      act_size_q  <= SIZE_W'(MIN_BLOCK_BYTES);
      act_count_q <= '0;
      act_end_q   <= '0;
      head_q      <= '0;
      empty_q     <= 1'b1;
      tally_q     <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_base_q  <= cfg_base_d;
      cfg_size_q  <= cfg_size_d;
      cfg_count_q <= cfg_count_d;
      act_base_q  <= act_base_d;
      act_size_q  <= act_size_d;
      act_count_q <= act_count_d;
      act_end_q   <= act_end_d;
      head_q      <= head_d;
      empty_q     <= empty_d;
      tally_q     <= tally_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_addr_q  <= op_addr_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    step_q     <= step_d;
    link_idx_q <= link_idx_d;
    res_ok_q   <= res_ok_d;
    res_addr_q <= res_addr_d;
    m_data_q   <= m_data_d;
    m_ok_q     <= m_ok_d;
  end

endmodule
`default_nettype wire

>>> src/fbpa_checker.sv
// Port-level checker of the allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_block_pool_allocator_core_defines.svh"
module fbpa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // one item at a time: busy right after an accept
  `FBPA_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // a stalled result holds
  `FBPA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // a failed operation grants no address
  `FBPA_ASSERT(a_fail_zero_addr, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)

  // free count never exceeds the pool capacity
  `FBPA_ASSERT(a_tally_bound, m_axis_tvalid |-> m_axis_tdata[40:32] <= 9'd256)

  // no result once reset has been seen by a clock edge
  `FBPA_ASSERT_RST(a_reset_quiet, !rst_ni |=> !m_axis_tvalid)

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

>>> verif/tb_fixed_block_pool_allocator_core.sv
// Self-checking testbench of the fixed block pool allocator core.
`timescale 1ns / 1ps
module tb_fixed_block_pool_allocator_core;
  import fbpa_pkg::*;

  // Opcode value with no meaning; the block must answer it with a plain failure.
  localparam logic [1:0]  OP_NONE    = 2'd3;
  // Longest legal quiet spell is an init of 256 blocks plus output stalls.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 300;

  // One result item as the pool should report it.
  typedef struct packed {
    logic        ok;
    logic [31:0] grant;
    logic [8:0]  nfree;
  } pool_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = 2'd0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] block_address
  logic [1:0]  s_axis_tuser = '0;   // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [31:0] granted_address, [40:32] blocks_free
  logic [0:0]  m_axis_tuser;        // [0] success

  fixed_block_pool_allocator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pool predictor: programmed geometry, latched geometry and the free list.
  // ---------------------------------------------------------------------------
  logic [31:0] cfg_base = '0;
  logic [15:0] cfg_size = 16'd4;
  logic [8:0]  cfg_count = 9'd1;

  logic [7:0]  link_next [BLOCKS];
  logic        link_last [BLOCKS];
  logic [7:0]  head = '0;
  logic        empty = 1'b1;
  logic [8:0]  tally = '0;
  logic [31:0] act_base = '0;
  logic [15:0] act_size = 16'd4;
  logic [8:0]  act_count = '0;

  pool_result_t pending_results[$];   // expected result items, oldest first
  logic [31:0]  granted_blocks[$];    // addresses handed out and not yet returned
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  bit           steady = 1'b0;        // set: neither side idles

  function automatic logic [31:0] block_addr(input int unsigned idx);
    return 32'(64'(act_base) + 64'(idx) * 64'(act_size));
  endfunction

  // Applies one item to the predicted pool and returns the result it must give.
  function automatic pool_result_t pool_apply(input logic [1:0] opc, input logic [31:0] addr);
    pool_result_t     r;
    logic [15:0]      blk;
    longint unsigned  span;
    longint unsigned  top;
    longint unsigned  off;
    int unsigned      idx;
    int unsigned      i;
    r = '0;
    case (opc)
      OP_INIT: begin
        blk  = (cfg_size < MIN_BLOCK_BYTES) ? 16'(MIN_BLOCK_BYTES) : cfg_size;
        span = 64'(blk) * 64'(cfg_count);
        if (cfg_count != 0 && cfg_count <= BLOCKS && cfg_base != 0 &&
            64'(cfg_base) + span <= 64'h1_0000_0000) begin
          act_base  = cfg_base;
          act_size  = blk;
          act_count = cfg_count;
          tally     = cfg_count;
          for (i = 0; i < cfg_count; i++) begin
            link_next[i] = (i + 1 < cfg_count) ? 8'(i + 1) : 8'd0;
            link_last[i] = (i + 1 == cfg_count);
          end
          head  = '0;
          empty = 1'b0;
          r.ok  = 1'b1;
        end
      end
      OP_ALLOC: begin
        if (!empty) begin
          idx     = 32'(head);
          r.grant = block_addr(idx);
          if (link_last[idx]) empty = 1'b1;
          else head = link_next[idx];
          if (tally > 0) tally--;
          r.ok = 1'b1;
        end
      end
      OP_FREE: begin
        if (addr != 0 && act_count != 0) begin
          top = 64'(act_base) + 64'(act_size) * 64'(act_count);
          if (addr >= act_base && 64'(addr) < top) begin
            off = 64'(addr - act_base);
            if (off % act_size == 0) begin
              idx            = 32'(off / act_size);
              link_next[idx] = head;
              link_last[idx] = empty;
              head           = 8'(idx);
              empty          = 1'b0;
              if (tally < BLOCKS) tally++;
              r.ok = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.nfree = tally;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side: inputs change on the falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] opc, input logic [31:0] addr,
                           output pool_result_t res);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= opc;
    do @(posedge clk_i); while (!s_axis_tready);
    res = pool_apply(opc, addr);
    pending_results.push_back(res);
    if (opc == OP_ALLOC && res.ok) granted_blocks.push_back(res.grant);
    if (opc == OP_INIT && res.ok) granted_blocks.delete();
  endtask

  // Stop sending and wait until every expected item has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_POOL_BASE:   cfg_base  = val;
      REG_BLOCK_SIZE:  cfg_size  = val[15:0];
      REG_BLOCK_COUNT: cfg_count = val[8:0];
      default: ;
    endcase
  endtask

  // Geometry is only written while the block is idle.
  task automatic program_pool(input logic [31:0] base, input logic [15:0] blk,
                              input logic [8:0] cnt);
    wait_idle();
    write_reg(REG_POOL_BASE, base);
    write_reg(REG_BLOCK_SIZE, 32'(blk));
    write_reg(REG_BLOCK_COUNT, 32'(cnt));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset: nothing latched, so alloc, free, an unused opcode and init (base 0) all fail.
  task automatic test_empty_pool();
    pool_result_t r;
    send_item(OP_ALLOC, 32'h0000_0000, r);
    send_item(OP_FREE, 32'h0000_0004, r);
    send_item(OP_FREE, 32'h0000_0000, r);
    send_item(OP_NONE, 32'hFFFF_FFFF, r);
    send_item(OP_INIT, 32'h5555_AAAA, r);
  endtask

  // Zero count, count above the pool, base 0 and a region past 4 GiB.
  task automatic test_init_refusals();
    pool_result_t r;
    program_pool(32'h0000_1000, 16'd1, 9'd0);
    send_item(OP_INIT, 32'h0, r);
    program_pool(32'h0000_1000, 16'd1, 9'd257);
    send_item(OP_INIT, 32'h0, r);
    program_pool(32'h0000_1000, 16'd1, 9'd511);
    send_item(OP_INIT, 32'h0, r);
    program_pool(32'hFF01_0001, 16'hFFFF, 9'd256);
    send_item(OP_INIT, 32'h0, r);
    program_pool(32'h0000_0000, 16'd8, 9'd4);
    send_item(OP_INIT, 32'h0, r);
  endtask

  // One-block pool flush with the top of memory, then the widest pool.
  task automatic test_pool_edges();
    pool_result_t r;
    program_pool(32'hFFFF_FFFC, 16'd1, 9'd1);        // size raised to 4
    send_item(OP_INIT, 32'hAAAA_5555, r);
    send_item(OP_ALLOC, 32'h0, r);
    send_item(OP_ALLOC, 32'h0, r);                    // list empty
    send_item(OP_FREE, 32'hFFFF_FFFB, r);             // below base
    send_item(OP_FREE, 32'hFFFF_FFFF, r);             // off block boundary
    send_item(OP_FREE, 32'hFFFF_FFFC, r);
    send_item(OP_FREE, 32'hFFFF_FFFC, r);             // double free goes through
    send_item(OP_ALLOC, 32'h0, r);
    send_item(OP_ALLOC, 32'h0, r);
    send_item(OP_ALLOC, 32'h0, r);                    // free count stuck at zero
    program_pool(32'h0000_1000, 16'hFFFF, 9'd256);
    send_item(OP_INIT, 32'h0, r);
    send_item(OP_ALLOC, 32'h0, r);
    send_item(OP_FREE, 32'h0000_1001, r);
    send_item(OP_FREE, 32'h0000_1000 + 32'hFFFF * 256, r);  // one past the end
    send_item(OP_FREE, 32'h0000_1000 + 32'hFFFF * 255, r);  // count back to 256
  endtask

  // Full pool, a few double frees past saturation, then drain below zero.
  task automatic test_saturation_walk();
    pool_result_t r;
    program_pool(32'h0004_0000, 16'($urandom_range(16, 1)), 9'd256);
    send_item(OP_INIT, $urandom, r);
    repeat (3) send_item(OP_FREE, block_addr($urandom_range(255, 0)), r);
    repeat (262) send_item(OP_ALLOC, $urandom, r);
  endtask

  // Phases of random geometry; inside each, mostly proper alloc/free traffic.
  task automatic test_random_traffic(input int unsigned budget);
    pool_result_t    r;
    int unsigned     sent;
    int unsigned     pick;
    int unsigned     k;
    logic [15:0]     blk;
    logic [8:0]      cnt;
    logic [31:0]     base;
    logic [31:0]     addr;
    longint unsigned span;
    sent   = 0;
    steady = 1'b1;
    while (sent < budget) begin
      if (sent > 150) steady = 1'b0;
      case ($urandom_range(9))
        8:       blk = 16'hFFFF;
        9:       blk = 16'd1;
        5, 6, 7: blk = 16'($urandom_range(65535, 1));
        default: blk = 16'($urandom_range(8, 1));
      endcase
      pick = $urandom_range(99);
      if (pick < 70)      cnt = 9'($urandom_range(12, 1));
      else if (pick < 85) cnt = 9'($urandom_range(256, 13));
      else if (pick < 90) cnt = 9'd256;
      else if (pick < 94) cnt = 9'd0;
      else if (pick < 97) cnt = 9'($urandom_range(511, 257));
      else                cnt = 9'd1;
      span = 64'((blk < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : blk) * 64'(cnt);
      case ($urandom_range(9))
        0:       base = 32'h0;
        1:       base = 32'(64'h1_0000_0000 - span);       // ends exactly at the top
        2:       base = 32'(64'h1_0000_0000 - span) + 1;   // one byte too far
        default: base = $urandom_range(32'(64'hFFFF_FFFF - span), 1);
      endcase
      program_pool(base, blk, cnt);
      send_item(OP_INIT, $urandom, r);
      sent++;
      repeat ($urandom_range(60, 25)) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          send_item(OP_ALLOC, $urandom, r);
        end else if (pick < 72) begin
          if (granted_blocks.size() != 0) begin
            k    = $urandom_range(granted_blocks.size() - 1, 0);
            addr = granted_blocks[k];
            granted_blocks.delete(k);
            send_item(OP_FREE, addr, r);
          end else begin
            send_item(OP_ALLOC, $urandom, r);
          end
        end else if (pick < 80) begin
          // any block of the pool, free or not
          addr = (act_count != 0) ? block_addr($urandom_range(act_count - 1, 0)) : $urandom;
          send_item(OP_FREE, addr, r);
        end else if (pick < 88) begin
          send_item(OP_FREE, $urandom, r);
        end else if (pick < 94) begin
          case ($urandom_range(4))
            0:       addr = act_base - 1;
            1:       addr = block_addr(act_count);
            2:       addr = block_addr($urandom_range(act_count, 0)) +
                            $urandom_range(act_size - 1, 1);
            3:       addr = 32'h0;
            default: addr = 32'hFFFF_FFFF;
          endcase
          send_item(OP_FREE, addr, r);
        end else if (pick < 97) begin
          send_item(OP_NONE, $urandom, r);
        end else begin
          send_item(OP_INIT, $urandom, r);
        end
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, in-order compare against predictions.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 23);
  end

  always @(posedge clk_i) begin : result_check
    pool_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ok=%0d grant=%h free=%0d",
                   m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[40:32]);
      end else begin
        want = pending_results.pop_front();
        if (want.ok !== m_axis_tuser[0] || want.grant !== m_axis_tdata[31:0] ||
            want.nfree !== m_axis_tdata[40:32]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ok=%0d grant=%h free=%0d, got ok=%0d grant=%h free=%0d",
                     want.ok, want.grant, want.nfree,
                     m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[40:32]);
        end
      end
    end
  end

  // Watchdog: too long without any item moving or any register write.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_pool();
    test_init_refusals();
    test_pool_edges();
    test_saturation_walk();
    test_random_traffic(510);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
